// ----- sv/bf3_pkg.sv -----
`default_nettype none

package bf3_pkg;

  // Width of the frame size registers
  localparam int unsigned SizeW = 11;

  // 3x3 window
  localparam int unsigned WinTaps    = 9;
  localparam int unsigned WinDivisor = 9;

  // Control from the front stage to the window stage
  typedef struct packed {
    logic shift;  // a word leaves the front stage and enters the window
    logic emit;   // that word is at an interior position
    logic last;   // that word closes the frame
  } bf3_win_ctrl_t;

endpackage

`default_nettype wire

// ----- sv/bf3_line_buf.sv -----
`default_nettype none

module bf3_line_buf #(
  parameter int unsigned DEPTH  = 1024,
  parameter int unsigned DATA_W = 8,
  localparam int unsigned AddrW = $clog2(DEPTH)
) (
  input  wire logic              clk_i,
  input  wire logic              rd_en_i,
  input  wire logic [AddrW-1:0]  rd_addr_i,
  output logic      [DATA_W-1:0] rd_data_o,
  input  wire logic              wr_en_i,
  input  wire logic [AddrW-1:0]  wr_addr_i,
  input  wire logic [DATA_W-1:0] wr_data_i
);

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

`default_nettype wire

// ----- sv/bf3_window.sv -----
`default_nettype none

module bf3_window
  import bf3_pkg::*;
#(
  parameter int unsigned PIXEL_BITS = 8
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire bf3_win_ctrl_t         ctrl_i,
  input  wire logic [PIXEL_BITS-1:0] top_i,
  input  wire logic [PIXEL_BITS-1:0] mid_i,
  input  wire logic [PIXEL_BITS-1:0] pix_i,
  output logic      [PIXEL_BITS-1:0] mean_o,
  output logic                       last_o
);

  // Sum of nine taps needs four extra bits
  localparam int unsigned SumW   = PIXEL_BITS + 4;
  // sum / 9 == (sum * Recip) >> Shift, exact for every sum below 2**SumW
  localparam int unsigned Shift  = SumW + 4;
  localparam int unsigned RecipW = Shift - 2;
  localparam longint unsigned Recip =
      ((64'd1 << Shift) + 64'(WinDivisor) - 64'd1) / 64'(WinDivisor);
  localparam int unsigned ProdW  = SumW + RecipW;

  logic [WinTaps-1:0][PIXEL_BITS-1:0] win_q, win_d;
  logic [SumW-1:0]                    sum;
  logic [ProdW-1:0]                   prod;
  logic [PIXEL_BITS-1:0]              mean_q, mean_d;
  logic                               last_q, last_d;

  // rows: 0 upper, 1 middle, 2 current; columns shift toward tap 0
  always_comb begin
    win_d = win_q;
    for (int i = 0; i < 3; i++) begin
      win_d[i*3+0] = win_q[i*3+1];
      win_d[i*3+1] = win_q[i*3+2];
    end
    win_d[2] = top_i;
    win_d[5] = mid_i;
    win_d[8] = pix_i;
  end

  always_comb begin
    sum = '0;
    for (int i = 0; i < WinTaps; i++) begin
      sum = sum + SumW'(win_d[i]);
    end
  end

  assign prod   = ProdW'(sum) * ProdW'(RecipW'(Recip));
  assign mean_d = prod[Shift +: PIXEL_BITS];
  assign last_d = ctrl_i.last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q <= '0;
    end else if (ctrl_i.shift) begin
      win_q <= win_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.shift && ctrl_i.emit) begin
      mean_q <= mean_d;
      last_q <= last_d;
    end
  end

  assign mean_o = mean_q;
  assign last_o = last_q;

endmodule

`default_nettype wire

// ----- sv/box_filter_3x3_mean.sv -----
`default_nettype none

// 3x3 box filter, truncated mean. Pixels stream in raster order on the pixel
// channel, one word per clock; each interior position gives one word on the
// mean channel holding floor(sum of the nine neighbors / 9), and frame_last_o
// marks the result from the last column of the last row. Border rows and
// columns give no result. The front stage registers the pixel below and right
// of a center and the two line buffer reads; the window, adder tree and
// reciprocal multiply then fill the result register. The sustained rate is
// one pixel per clock while results are taken; a stalled result holds the
// front stage only once an interior pixel reaches it, so border pixels keep
// flowing and one interior pixel is taken while a result waits. Frame width
// and height sit at APB byte addresses 0 and 4 (11 bits each, reset 1000);
// values below 3 act as 3 and values above MAX_WIDTH / MAX_HEIGHT act as
// that maximum, while reads return the written bits. Write them only while
// the block is idle. The line buffers need no clearing pass after reset.
module box_filter_3x3_mean
  import bf3_pkg::*;
#(
  parameter int unsigned MAX_WIDTH  = 1024,
  parameter int unsigned MAX_HEIGHT = 1024,
  parameter int unsigned PIXEL_BITS = 8
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  // pixel channel
  input  wire logic                  pixel_valid_i,
  output logic                       pixel_stall_o,
  input  wire logic [PIXEL_BITS-1:0] pixel_in_i,
  // result channel
  output logic                       mean_valid_o,
  input  wire logic                  mean_stall_i,
  output logic      [PIXEL_BITS-1:0] mean_out_o,
  output logic                       frame_last_o,
  // configuration
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [2:0]            paddr,
  input  wire logic [31:0]           pwdata,
  output logic      [31:0]           prdata,
  output logic                       pready
);

  localparam int unsigned ColW = $clog2(MAX_WIDTH);
  localparam int unsigned RowW = $clog2(MAX_HEIGHT);
  localparam int unsigned MaxW = (MAX_WIDTH > MAX_HEIGHT) ? MAX_WIDTH : MAX_HEIGHT;
  // wide enough for a size register, for either maximum and for count + 1
  localparam int unsigned ExtW = (SizeW > $clog2(MaxW + 1)) ? SizeW : $clog2(MaxW + 1);
  localparam logic [SizeW-1:0] SizeReset = SizeW'(1000);

  // register index codes (paddr[2])
  localparam logic RegFrameWidth  = 1'b0;
  localparam logic RegFrameHeight = 1'b1;

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic [SizeW-1:0] frame_width_q, frame_height_q;
  logic             cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_width_q  <= SizeReset;
      frame_height_q <= SizeReset;
    end else if (cfg_wr) begin
      unique case (paddr[2])
        RegFrameWidth:  frame_width_q  <= pwdata[SizeW-1:0];
        RegFrameHeight: frame_height_q <= pwdata[SizeW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      RegFrameWidth:  prdata = 32'(frame_width_q);
      RegFrameHeight: prdata = 32'(frame_height_q);
      default:        prdata = '0;
    endcase
  end

  // Effective frame size after clamping
  logic [ExtW-1:0] width_ext, height_ext, width_eff, height_eff;

  assign width_ext  = ExtW'(frame_width_q);
  assign height_ext = ExtW'(frame_height_q);

  always_comb begin
    if (width_ext < ExtW'(3)) begin
      width_eff = ExtW'(3);
    end else if (width_ext > ExtW'(MAX_WIDTH)) begin
      width_eff = ExtW'(MAX_WIDTH);
    end else begin
      width_eff = width_ext;
    end
    if (height_ext < ExtW'(3)) begin
      height_eff = ExtW'(3);
    end else if (height_ext > ExtW'(MAX_HEIGHT)) begin
      height_eff = ExtW'(MAX_HEIGHT);
    end else begin
      height_eff = height_ext;
    end
  end

  // ---------------------------------------------------------------------------
  // Handshake and front stage
  // ---------------------------------------------------------------------------
  logic                  s1_valid_q, s1_valid_d;
  logic                  s1_emit_q, s1_last_q;
  logic [ColW-1:0]       s1_col_q;
  logic [PIXEL_BITS-1:0] s1_pix_q;
  logic                  out_valid_q, out_valid_d;
  logic                  out_free, s1_adv, accept;

  // output slot is free this edge if empty or being taken
  assign out_free      = !out_valid_q || !mean_stall_i;
  // a non-interior word leaves the front stage without the output slot
  assign s1_adv        = s1_valid_q && (!s1_emit_q || out_free);
  assign pixel_stall_o = s1_valid_q && !s1_adv;
  assign accept        = pixel_valid_i && !pixel_stall_o;

  // raster position
  logic [ColW-1:0] col_q, col_d;
  logic [RowW-1:0] row_q, row_d;
  logic [ExtW-1:0] col_inc, row_inc;
  logic            col_wrap, row_wrap, at_interior;

  assign col_inc     = ExtW'(col_q) + ExtW'(1);
  assign row_inc     = ExtW'(row_q) + ExtW'(1);
  assign col_wrap    = col_inc >= width_eff;
  assign row_wrap    = row_inc >= height_eff;
  assign at_interior = (ExtW'(col_q) >= ExtW'(2)) && (ExtW'(row_q) >= ExtW'(2));

  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (col_wrap) begin
      col_d = '0;
      row_d = row_wrap ? '0 : RowW'(row_inc);
    end else begin
      col_d = ColW'(col_inc);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else if (accept) begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (accept) begin
      s1_valid_d = 1'b1;
    end else if (s1_adv) begin
      s1_valid_d = 1'b0;
    end
    out_valid_d = out_valid_q;
    if (s1_adv && s1_emit_q) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && !mean_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      s1_emit_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
      if (accept) begin
        s1_emit_q <= at_interior;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_pix_q  <= pixel_in_i;
      s1_col_q  <= col_q;
      s1_last_q <= col_wrap && row_wrap;
    end
  end

  // ---------------------------------------------------------------------------
  // Line buffers: read on accept, rotate when the word enters the window
  // ---------------------------------------------------------------------------
  logic [PIXEL_BITS-1:0] top_rd, mid_rd;

  bf3_line_buf #(
    .DEPTH  (MAX_WIDTH),
    .DATA_W (PIXEL_BITS)
  ) u_line_upper (
    .clk_i     (clk_i),
    .rd_en_i   (accept),
    .rd_addr_i (col_q),
    .rd_data_o (top_rd),
    .wr_en_i   (s1_adv),
    .wr_addr_i (s1_col_q),
    .wr_data_i (mid_rd)
  );

  bf3_line_buf #(
    .DEPTH  (MAX_WIDTH),
    .DATA_W (PIXEL_BITS)
  ) u_line_middle (
    .clk_i     (clk_i),
    .rd_en_i   (accept),
    .rd_addr_i (col_q),
    .rd_data_o (mid_rd),
    .wr_en_i   (s1_adv),
    .wr_addr_i (s1_col_q),
    .wr_data_i (s1_pix_q)
  );

  // ---------------------------------------------------------------------------
  // Window, sum and divide, result register
  // ---------------------------------------------------------------------------
  bf3_win_ctrl_t win_ctrl;

  assign win_ctrl.shift = s1_adv;
  assign win_ctrl.emit  = s1_emit_q;
  assign win_ctrl.last  = s1_last_q;

  bf3_window #(
    .PIXEL_BITS (PIXEL_BITS)
  ) u_window (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (win_ctrl),
    .top_i  (top_rd),
    .mid_i  (mid_rd),
    .pix_i  (s1_pix_q),
    .mean_o (mean_out_o),
    .last_o (frame_last_o)
  );

  assign mean_valid_o = out_valid_q;

`ifndef SYNTHESIS
  // input stalls only behind a held front stage
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    pixel_stall_o |-> s1_valid_q && s1_emit_q && out_valid_q)
    else $error("pixel stall without a held result");

  // a line buffer write never hits the column being read
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && s1_adv |-> s1_col_q != col_q)
    else $error("line buffer read/write collision");

  // an interior word leaving the front stage shows up as a result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_adv && s1_emit_q |=> mean_valid_o)
    else $error("interior word lost");
`endif

endmodule

`default_nettype wire
